// ----- hw/rtl/mlomq_pkg.sv -----
// ----------------------------------------------------------------------------
// mlomq_pkg
// Types, sizes and helpers shared by the ordered merge queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlomq_pkg;

  localparam int LANES      = 8;
  localparam int RING_DEPTH = 16;
  localparam int SLOTS      = LANES * RING_DEPTH;

  localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LCNT_W  = $clog2(LANES + 1);
  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TOTAL_W = $clog2(SLOTS + 1);

  localparam int FILE_W  = 24;
  localparam int VER_W   = 8;
  localparam int BLK_W   = 32;
  localparam int KEY_W   = FILE_W + VER_W + BLK_W;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = KEY_W + TAG_W;

  localparam int CFG_LANES_W = 4;
  localparam int CFG_DEPTH_W = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0]   CFG_LANES_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0]   CFG_DEPTH_IDX = 2'd1;
  localparam logic [CFG_LANES_W-1:0] LANES_RESET   = 4'd8;
  localparam logic [CFG_DEPTH_W-1:0] DEPTH_RESET   = 5'd16;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BAD_LANE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_POP
  } state_t;

  typedef struct packed {
    logic [FILE_W-1:0] file;
    logic [VER_W-1:0]  ver;
    logic [BLK_W-1:0]  blk;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [LANE_W-1:0] l,
                                                  input logic [PTR_W-1:0]  p);
    return SLOT_W'(int'(l) * RING_DEPTH + int'(p));
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/multi_lane_ordered_merge_queue.sv -----
// ----------------------------------------------------------------------------
// multi_lane_ordered_merge_queue
// Per-lane ring FIFOs merged in key order on get.
//
// A command word is taken when start is high and busy is low. in_operation
// selects put (append to in_lane), get (pop the smallest head key across
// the lanes in use, ties to the lowest lane) or flush (empty every lane).
// Every command returns one result word, shown for one cycle with
// out_valid high; the receiver cannot stall it.
// Put, flush and the unused code finish in the accept cycle: the result
// shows in the next cycle and busy never rises, so they run one per cycle.
// A get walks the lane heads through the single entry RAM read port and
// one 64-bit comparator, one lane per cycle: busy stays high through the
// scan over the effective lane count (lanes_in_use held to 1..8), then the
// last and pop states, and the result shows in the cycle after the pop, so
// a new get is taken only once the last one is through.
// cfg_we writes lanes_in_use (index 0) or depth_in_use (index 1); the user
// must make writes only while idle, which the block itself does not enforce.
// Reset empties all lanes, clears the total and restores 8 lanes of depth
// 16. Entry storage is not cleared; only written entries are ever used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_lane_ordered_merge_queue
  import mlomq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_operation,
  input  wire logic [2:0]            in_lane,
  input  wire logic [FILE_W-1:0]     in_file_number,
  input  wire logic [VER_W-1:0]      in_version_number,
  input  wire logic [BLK_W-1:0]      in_block_number,
  input  wire logic [TAG_W-1:0]      in_entry_tag,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [TAG_W-1:0]           out_tag,
  output logic [FILE_W-1:0]          out_file,
  output logic [VER_W-1:0]           out_version,
  output logic [BLK_W-1:0]           out_block,
  output logic [2:0]                 out_lane,
  output logic [7:0]                 out_total_entries
);

  state_t state_r, state_nxt;

  logic [CFG_LANES_W-1:0] lanes_cfg_r;
  logic [CFG_DEPTH_W-1:0] depth_cfg_r;
  logic [LCNT_W-1:0]      n_eff;
  logic [FILL_W-1:0]      d_eff;

  logic [PTR_W-1:0]   head_r [LANES];
  logic [PTR_W-1:0]   head_nxt [LANES];
  logic [PTR_W-1:0]   tail_r [LANES];
  logic [PTR_W-1:0]   tail_nxt [LANES];
  logic [FILL_W-1:0]  fill_r [LANES];
  logic [FILL_W-1:0]  fill_nxt [LANES];
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic [LANE_W-1:0] scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [LANE_W-1:0] pend_lane_r, pend_lane_nxt;
  logic              found_r, found_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  logic [TAG_W-1:0]  best_tag_r, best_tag_nxt;
  logic [LANE_W-1:0] best_lane_r, best_lane_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  entry_t            out_entry_r, out_entry_nxt;
  logic [2:0]        out_lane_r, out_lane_nxt;
  logic [7:0]        out_total_r, out_total_nxt;

  logic              acc;
  op_t               op;
  logic [LANE_W-1:0] put_lane;
  logic              lane_ok;
  logic              lane_full;
  logic              scan_last;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic              take;

  mlomq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;
  assign op   = op_t'(in_operation);

  always_comb begin
    if (lanes_cfg_r == '0) begin
      n_eff = LCNT_W'(1);
    end else if (32'(lanes_cfg_r) > LANES) begin
      n_eff = LCNT_W'(LANES);
    end else begin
      n_eff = LCNT_W'(lanes_cfg_r);
    end
    if (depth_cfg_r == '0) begin
      d_eff = FILL_W'(1);
    end else if (32'(depth_cfg_r) > RING_DEPTH) begin
      d_eff = FILL_W'(RING_DEPTH);
    end else begin
      d_eff = FILL_W'(depth_cfg_r);
    end
  end

  assign put_lane  = LANE_W'(in_lane);
  assign lane_ok   = 32'(in_lane) < 32'(n_eff);
  assign lane_full = fill_r[put_lane] >= d_eff;
  assign scan_last = 32'(scan_r) == 32'(n_eff) - 1;

  assign ram_we    = acc && (op == OP_PUT) && lane_ok && !lane_full;
  assign ram_waddr = slot_addr(put_lane, tail_r[put_lane]);
  assign ram_wdata = '{file: in_file_number, ver: in_version_number,
                       blk: in_block_number, tag: in_entry_tag};
  assign ram_raddr = slot_addr(scan_r, head_r[scan_r]);

  // shared key comparator
  assign rd_key = {ram_rdata.file, ram_rdata.ver, ram_rdata.blk};
  assign take   = pend_r && (!found_r || (rd_key < best_key_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && (op == OP_GET)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:  state_nxt = S_POP;
      S_POP:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    pend_lane_nxt = pend_lane_r;
    found_nxt     = found_r;
    best_key_nxt  = best_key_r;
    best_tag_nxt  = best_tag_r;
    best_lane_nxt = best_lane_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_entry_nxt  = '0;
    out_lane_nxt   = '0;

    if (take) begin
      found_nxt     = 1'b1;
      best_key_nxt  = rd_key;
      best_tag_nxt  = ram_rdata.tag;
      best_lane_nxt = pend_lane_r;
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_valid_nxt = (op != OP_GET);
          case (op)
            OP_PUT: begin
              if (!lane_ok) begin
                out_status_nxt = ST_BAD_LANE;
              end else if (lane_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                tail_nxt[put_lane] = ptr_inc(tail_r[put_lane]);
                fill_nxt[put_lane] = fill_r[put_lane] + 1'b1;
                total_nxt          = total_r + 1'b1;
              end
            end
            OP_GET: begin
              scan_nxt  = '0;
              found_nxt = 1'b0;
            end
            OP_FLUSH: begin
              head_nxt  = tail_r;
              fill_nxt  = '{default: '0};
              total_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        pend_nxt      = (fill_r[scan_r] != '0);
        pend_lane_nxt = scan_r;
        scan_nxt      = scan_r + 1'b1;
      end
      S_LAST: ;
      S_POP: begin
        out_valid_nxt = 1'b1;
        if (found_r) begin
          out_entry_nxt = '{file: best_key_r[KEY_W-1 -: FILE_W],
                            ver: best_key_r[BLK_W +: VER_W],
                            blk: best_key_r[BLK_W-1:0], tag: best_tag_r};
          out_lane_nxt  = 3'(best_lane_r);
          head_nxt[best_lane_r] = ptr_inc(head_r[best_lane_r]);
          fill_nxt[best_lane_r] = fill_r[best_lane_r] - 1'b1;
          if (total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
        end else begin
          out_status_nxt = ST_EMPTY;
        end
      end
      default: ;
    endcase

    out_total_nxt = (32'(total_nxt) > 255) ? 8'hFF : 8'(total_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lanes_cfg_r <= LANES_RESET;
      depth_cfg_r <= DEPTH_RESET;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      fill_r      <= '{default: '0};
      total_r     <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LANES_IDX: lanes_cfg_r <= cfg_data[CFG_LANES_W-1:0];
          CFG_DEPTH_IDX: depth_cfg_r <= cfg_data[CFG_DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    pend_lane_r <= pend_lane_nxt;
    best_key_r  <= best_key_nxt;
    best_tag_r  <= best_tag_nxt;
    best_lane_r <= best_lane_nxt;
    if (out_valid_nxt) begin
      out_status_r <= out_status_nxt;
      out_entry_r  <= out_entry_nxt;
      out_lane_r   <= out_lane_nxt;
      out_total_r  <= out_total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_tag           = out_entry_r.tag;
  assign out_file          = out_entry_r.file;
  assign out_version       = out_entry_r.ver;
  assign out_block         = out_entry_r.blk;
  assign out_lane          = out_lane_r;
  assign out_total_entries = out_total_r;

  a_get_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (op == OP_GET) |=> busy && !out_valid)
    else $error("get did not start a scan");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> out_valid && !busy)
    else $error("get finished without a result word");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= SLOTS)
    else $error("entry total above storage size");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_tag == '0) && (out_block == '0))
    else $error("refused or empty result carries entry data");

endmodule

`default_nettype wire

// ----- hw/rtl/mlomq_ram.sv -----
// ----------------------------------------------------------------------------
// mlomq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlomq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
